// ===== src/satl_pkg.sv =====
// Shared types and constants for the set-associative tag lookup unit.
// Used by the controller, the datapath and the top level; no dependencies.
package satl_pkg;

  localparam int ADDR_W   = 31;
  localparam int WAY_W    = 4;
  localparam int MOD_STEP = 4;
  localparam int MOD_CYC  = (ADDR_W + MOD_STEP - 1) / MOD_STEP;
  localparam int PAD_W    = MOD_CYC * MOD_STEP;
  localparam int CNT_W    = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic mod_step;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic mod_skip;
  } status_t;

endpackage

// ===== src/satl_ctrl.sv =====
// Sequencing state machine of the tag lookup unit.
// Depends on satl_pkg for the state enum and the command and status structs.
module satl_ctrl
  import satl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = status_i.mod_skip ? ST_READ : ST_MOD;
      end
      ST_MOD: begin
        if (status_i.mod_last) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (start_i) begin
          state_d = status_i.mod_skip ? ST_READ : ST_MOD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy_o       = !((state_q == ST_IDLE) || (state_q == ST_CMP));
    cmd_o.clr      = (state_q == ST_CLEAR);
    cmd_o.load     = !busy_o && start_i;
    cmd_o.mod_step = (state_q == ST_MOD);
    cmd_o.rd       = (state_q == ST_READ);
    cmd_o.commit   = (state_q == ST_CMP);
  end

endmodule

// ===== src/satl_datapath.sv =====
// Datapath of the tag lookup unit: set reduction, tag and metadata memories,
// way compare, victim selection and result registers. Depends on satl_pkg.
module satl_datapath
  import satl_pkg::*;
#(
  parameter int SETS      = 16,
  parameter int WAYS      = 10,
  parameter int TAG_SHIFT = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [ADDR_W-1:0]  address_i,
  output status_t            status_o,
  output logic               done_o,
  output logic               hit_o,
  output logic [WAY_W-1:0]   way_o
);

  localparam int  SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  REM_W  = SET_W + 1;
  localparam int  PTR_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  TAG_W  = ADDR_W - TAG_SHIFT;
  localparam int  META_W = PTR_W + WAYS;
  localparam bit  POW2   = ((SETS & (SETS - 1)) == 0);

  logic [ADDR_W-1:0] addr_q;
  logic [PAD_W-1:0]  sr_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [SET_W-1:0]  clr_q;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;

  logic [META_W-1:0]               meta_mem [SETS];
  logic [WAYS-1:0][TAG_W-1:0]      tag_mem  [SETS];
  logic [META_W-1:0]               meta_rd_q;
  logic [WAYS-1:0][TAG_W-1:0]      tag_rd_q;

  logic [PTR_W-1:0]            ptr_rd, victim, used, ptr_new;
  logic [WAYS-1:0]             valid_rd, valid_new, hit_vec;
  logic [PTR_W-1:0]            hit_way;
  logic                        hit_c;
  logic [WAYS-1:0][TAG_W-1:0]  tag_wr;
  logic                        meta_we;
  logic [SET_W-1:0]            meta_waddr;
  logic [META_W-1:0]           meta_wdata;

  logic done_q, hit_q;
  logic [WAY_W-1:0] way_q;

  // Operand registers and the remainder unit, MOD_STEP address bits per cycle.
  always_comb begin
    logic [REM_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < MOD_STEP; i++) begin
      r = {r[REM_W-2:0], sr_q[PAD_W-1-i]};
      if (r >= REM_W'(SETS)) r = r - REM_W'(SETS);
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= address_i;
      sr_q   <= PAD_W'(address_i);
      rem_q  <= '0;
    end else if (cmd_i.mod_step) begin
      sr_q  <= sr_q << MOD_STEP;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    if (SETS == 1) begin
      set_idx = '0;
    end else if (POW2) begin
      set_idx = addr_q[SET_W-1:0];
    end else begin
      set_idx = rem_q[SET_W-1:0];
    end
    tag = addr_q[ADDR_W-1:TAG_SHIFT];
  end

  assign status_o.clr_last = (clr_q == SET_W'(SETS - 1));
  assign status_o.mod_last = (cnt_q == CNT_W'(MOD_CYC - 1));
  assign status_o.mod_skip = POW2;

  // Compare, victim selection and write-back.
  always_comb begin
    ptr_rd   = meta_rd_q[META_W-1:WAYS];
    valid_rd = meta_rd_q[WAYS-1:0];
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_rd[w] && (tag_rd_q[w] == tag);
    end
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = PTR_W'(w);
    end
    hit_c = |hit_vec;
    if ({1'b0, ptr_rd} >= (PTR_W + 1)'(WAYS)) begin
      victim = ptr_rd - PTR_W'(WAYS);
    end else begin
      victim = ptr_rd;
    end
    used    = hit_c ? hit_way : victim;
    ptr_new = (used == '0) ? PTR_W'(WAYS - 1) : used - 1'b1;
    valid_new = valid_rd;
    tag_wr    = tag_rd_q;
    if (!hit_c) begin
      valid_new[victim] = 1'b1;
      tag_wr[victim]    = tag;
    end
    meta_we    = cmd_i.clr || cmd_i.commit;
    meta_waddr = cmd_i.clr ? clr_q : set_idx;
    meta_wdata = cmd_i.clr ? '0 : {ptr_new, valid_new};
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (cmd_i.rd) meta_rd_q <= meta_mem[set_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit_c) tag_mem[set_idx] <= tag_wr;
    if (cmd_i.rd) tag_rd_q <= tag_mem[set_idx];
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q <= hit_c;
      way_q <= WAY_W'(used);
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign way_o  = way_q;

endmodule

// ===== src/set_assoc_tag_lookup_rotating_victim_unit.sv =====
// Top level of the set-associative tag lookup unit with a rotating victim.
// Instantiates satl_ctrl and satl_datapath; depends on satl_pkg.
//
// A request is taken at a rising edge where start is high and busy is low;
// address_i carries the access address. The set is the address modulo SETS,
// the tag is the address shifted right by TAG_SHIFT. Each request produces
// exactly one result: done_o is high for one cycle with hit_o and way_o.
// The receiver cannot stall; a result is gone after its cycle.
// When SETS is a power of two, a request passes through the registered read of
// the set's tag and metadata rows and then the compare and write-back state, and
// the result strobe is registered from the commit; a new request can be taken in
// the compare and write-back state. For other set counts, the remainder unit
// runs first, reducing four address bits per cycle.
// After reset, busy stays high while a clearing pass zeroes the valid bits and
// victim pointers, one set per cycle.
module set_assoc_tag_lookup_rotating_victim_unit
  import satl_pkg::*;
#(
  parameter int SETS      = 16,
  parameter int WAYS      = 10,
  parameter int TAG_SHIFT = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] address_i,
  output logic              done_o,
  output logic              hit_o,
  output logic [WAY_W-1:0]  way_o
);

  cmd_t    cmd;
  status_t status;

  satl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  satl_datapath #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .TAG_SHIFT (TAG_SHIFT)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .address_i (address_i),
    .status_o  (status),
    .done_o    (done_o),
    .hit_o     (hit_o),
    .way_o     (way_o)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for set_assoc_tag_lookup_rotating_victim_unit.
// Tracks tags, valid bits and victim pointers per set to predict every lookup.
// Depends on satl_pkg and the unit's RTL; nothing else is read.
module tb
  import satl_pkg::*;
();

  localparam int TB_SETS  = 16;
  localparam int TB_WAYS  = 10;
  localparam int TB_SHIFT = 6;
  localparam int TAG_W    = ADDR_W - TB_SHIFT;
  localparam int N_RANDOM = 800;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } lookup_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                drain;
  } request_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] address_i;
  logic              done_o;
  logic              hit_o;
  logic [WAY_W-1:0]  way_o;

  logic [TAG_W-1:0] tag_mem [TB_SETS*TB_WAYS];
  bit               valid_mem [TB_SETS*TB_WAYS];
  bit [WAY_W-1:0]   victim_ptr [TB_SETS];

  request_t pending_q [$];
  lookup_t  lookup_q [$];
  bit       req_taken;
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_total;

  set_assoc_tag_lookup_rotating_victim_unit #(
    .SETS(TB_SETS),
    .WAYS(TB_WAYS),
    .TAG_SHIFT(TB_SHIFT)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .address_i(address_i),
    .done_o(done_o),
    .hit_o(hit_o),
    .way_o(way_o)
  );

  function automatic lookup_t lookup_access(logic [ADDR_W-1:0] addr);
    int unsigned      set_idx;
    int unsigned      base;
    logic [TAG_W-1:0] tag;
    lookup_t          r;
    set_idx = addr % TB_SETS;
    tag     = TAG_W'(addr >> TB_SHIFT);
    base    = set_idx * TB_WAYS;
    r.hit   = 1'b0;
    r.way   = '0;
    for (int w = 0; w < TB_WAYS; w++) begin
      if (!r.hit && valid_mem[base+w] && tag_mem[base+w] == tag) begin
        r.hit = 1'b1;
        r.way = WAY_W'(w);
      end
    end
    if (!r.hit) begin
      r.way = WAY_W'(victim_ptr[set_idx] % TB_WAYS);
      valid_mem[base+r.way] = 1'b1;
      tag_mem[base+r.way]   = tag;
    end
    victim_ptr[set_idx] = (r.way == 0) ? WAY_W'(TB_WAYS - 1) : r.way - 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    int unsigned       mode;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] addr;
    mode = $urandom_range(99);
    if (mode < 55) begin
      tag = TAG_W'($urandom_range(15));
    end else if (mode < 80) begin
      tag = TAG_W'($urandom_range(40));
    end else if (mode < 92) begin
      tag = TAG_W'({TAG_W{1'b1}} - TAG_W'($urandom_range(7)));
    end else begin
      tag = TAG_W'($urandom());
    end
    addr = {tag, TB_SHIFT'(0)};
    addr[5:0] = 6'($urandom_range(63));
    return addr;
  endfunction

  task automatic queue_request(logic [ADDR_W-1:0] addr, bit drain);
    request_t req;
    req.addr  = addr;
    req.drain = drain;
    pending_q.push_back(req);
  endtask

  task automatic flag_mismatch(string msg);
    if (n_errors < 100) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("tb: FAIL");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      address_i <= '0;
    end else begin
      if (start && !req_taken) begin
        start <= 1'b1;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && lookup_q.size() != 0) &&
                   $urandom_range(99) >= ((n_sent < n_total / 3) ? 19 :
                                          (n_sent < 2 * n_total / 3) ? 51 : 0)) begin
        start     <= 1'b1;
        address_i <= pending_q[0].addr;
        pending_q.pop_front();
        n_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          flag_mismatch($sformatf("result with no request pending: hit=%0d way=%0d",
                                  hit_o, way_o));
        end else begin
          if (hit_o !== lookup_q[0].hit) begin
            flag_mismatch($sformatf("hit got %0d expected %0d", hit_o, lookup_q[0].hit));
          end
          if (way_o !== lookup_q[0].way) begin
            flag_mismatch($sformatf("way got %0d expected %0d", way_o, lookup_q[0].way));
          end
          lookup_q.pop_front();
        end
      end
      if (start && !busy) begin
        lookup_q.push_back(lookup_access(address_i));
      end
      req_taken <= start && !busy;
    end
  end

  initial begin
    rst_ni = 1'b0;

    queue_request('0, 1'b0);
    queue_request('0, 1'b0);
    queue_request({ADDR_W{1'b1}}, 1'b0);
    queue_request({ADDR_W{1'b1}}, 1'b0);
    queue_request(ADDR_W'('h10), 1'b0);
    queue_request(ADDR_W'('h20), 1'b0);
    queue_request(ADDR_W'('h30), 1'b0);
    for (int t = 1; t <= TB_WAYS + 1; t++) begin
      queue_request(ADDR_W'((t << TB_SHIFT) | 1), 1'b0);
    end
    queue_request(ADDR_W'((5 << TB_SHIFT) | 1), 1'b0);
    queue_request(ADDR_W'((11 << TB_SHIFT) | 1), 1'b0);
    queue_request(ADDR_W'((12 << TB_SHIFT) | 1), 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      queue_request(random_address(), i % 200 == 0);
    end
    n_total = pending_q.size();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || start || lookup_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== set_assoc_tag_lookup_rotating_victim_unit.f =====
src/satl_pkg.sv
src/satl_ctrl.sv
src/satl_datapath.sv
src/set_assoc_tag_lookup_rotating_victim_unit.sv
dv/tb.sv
